>>> rtl/gls_pkg.sv
`default_nettype none
package gls_pkg;
	localparam int COORD_W   = 18;
	localparam int ACT_W     = 2;
	localparam int CELL_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 9;
	localparam int SQ_IN_W   = 38;
	localparam int ROOT_W    = 19;
	localparam int POS_W     = 32;

	localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TEST   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
endpackage
`default_nettype wire

>>> rtl/gls_in_if.sv
`default_nettype none
interface gls_in_if;
	logic                                valid;
	logic                                ready;
	logic [gls_pkg::ACT_W-1:0]           action;
	logic signed [gls_pkg::COORD_W-1:0]  start_x;
	logic signed [gls_pkg::COORD_W-1:0]  start_y;
	logic signed [gls_pkg::COORD_W-1:0]  end_x;
	logic signed [gls_pkg::COORD_W-1:0]  end_y;
	logic [gls_pkg::CELL_W-1:0]          cell_x;
	logic [gls_pkg::CELL_W-1:0]          cell_y;
	logic [gls_pkg::CELL_W-1:0]          cell_value;
	modport source (output valid, action, start_x, start_y, end_x, end_y, cell_x, cell_y,
		cell_value, input ready);
	modport sink (input valid, action, start_x, start_y, end_x, end_y, cell_x, cell_y,
		cell_value, output ready);
endinterface
`default_nettype wire

>>> rtl/gls_out_if.sv
`default_nettype none
interface gls_out_if;
	logic                      valid;
	logic                      ready;
	logic                      path_free;
	logic [gls_pkg::ACT_W-1:0] done_action;
	modport source (output valid, path_free, done_action, input ready);
	modport sink (input valid, path_free, done_action, output ready);
endinterface
`default_nettype wire

>>> rtl/gls_cfg_if.sv
`default_nettype none
interface gls_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gls_pkg::CFG_IDX_W-1:0] index;
	logic [gls_pkg::CFG_DW-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/gls_grid_mem.sv
`default_nettype none
module gls_grid_mem #(
	parameter int ROWS = 256,
	parameter int WORD = 256
) (
	input  wire logic                    clk,
	input  wire logic                    rd_en,
	input  wire logic [$clog2(ROWS)-1:0] rd_addr,
	output logic      [WORD-1:0]         rd_data,
	input  wire logic                    wr_en,
	input  wire logic [$clog2(ROWS)-1:0] wr_addr,
	input  wire logic [WORD-1:0]         wr_data
);
	logic [WORD-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/gls_sqrt.sv
`default_nettype none
module gls_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [gls_pkg::SQ_IN_W-1:0]  radicand,
	output logic                              done,
	output logic      [gls_pkg::ROOT_W-1:0]   root
);
	import gls_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [SQ_IN_W-1:0] val_q;
	logic [ROOT_W:0]    rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [ROOT_W+2:0]  rem_sh;
	logic [ROOT_W+2:0]  trial;
	logic               take;

	assign rem_sh = {rem_q, val_q[SQ_IN_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_sh >= trial;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= take ? (ROOT_W+1)'(rem_sh - trial) : (ROOT_W+1)'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q && !done)
		else $error("root unit did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("root unit done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0 && cnt_q <= CNT_W'(ROOT_W))
		else $error("root unit count out of range");
endmodule
`default_nettype wire

>>> rtl/gls_div.sv
`default_nettype none
module gls_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 19
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quot,
	output logic      [DEN_W-1:0] rem
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_sh;
	logic             take;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign take   = rem_sh >= {1'b0, den_q};
	assign quot   = quot_q;
	assign rem    = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= take ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
			quot_q <= {quot_q[NUM_W-2:0], take};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> rem_q < den_q)
		else $error("divider remainder not reduced");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("divider done while busy");
endmodule
`default_nettype wire

>>> rtl/grid_line_of_sight_checker.sv
// Channel  Role    Transaction
// in_ch    sink    one action: write cell, clear grid or test path
// out_ch   source  one result per action: path_free, done_action
// cfg      sink    register write: index 0 map_width, 1 map_height
//
// A cell write reads the grid row and writes it back; a clear writes one grid row a cycle.
// A path test checks the end point, forms the squares, takes the root, checks the
// length, runs the step division for x and y and then marches the path, each pixel
// of path length one read of the row memory.
// After reset a clearing pass over all MAX_WIDTH rows runs before in_ch.ready rises.
// A new transaction is taken while a result still waits on out_ch.
`default_nettype none
module grid_line_of_sight_checker #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gls_in_if.sink    in_ch,
	gls_out_if.source out_ch,
	gls_cfg_if.sink   cfg
);
	import gls_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int N_W   = ROOT_W - FRAC_BITS;
	localparam int NUM_W = COORD_W + FRAC_BITS;
	localparam int CAP   = MAX_WIDTH + MAX_HEIGHT;
	localparam logic [CFG_DW-1:0] W_RST = CFG_DW'((256 > MAX_WIDTH) ? MAX_WIDTH : 256);
	localparam logic [CFG_DW-1:0] H_RST = CFG_DW'((256 > MAX_HEIGHT) ? MAX_HEIGHT : 256);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_WRITE = 14'b00000000000010,
		S_CLEAR = 14'b00000000000100,
		S_PROBE = 14'b00000000001000,
		S_CHECK = 14'b00000000010000,
		S_SQ1   = 14'b00000000100000,
		S_SQ2   = 14'b00000001000000,
		S_SUM   = 14'b00000010000000,
		S_SQRT  = 14'b00000100000000,
		S_EVAL  = 14'b00001000000000,
		S_DIVX  = 14'b00010000000000,
		S_DIVY  = 14'b00100000000000,
		S_STEP  = 14'b01000000000000,
		S_POS   = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   boot_q;
	logic   end_q;
	logic   free_q;
	logic   out_valid_q;
	logic   out_free_q;
	logic [ACT_W-1:0]  act_q;
	logic [ACT_W-1:0]  out_act_q;
	logic [CFG_DW-1:0] width_q;
	logic [CFG_DW-1:0] height_q;
	logic [XW-1:0]     clr_idx_q;
	logic [XW-1:0]     wr_row_q;
	logic [YW-1:0]     wr_col_q;
	logic              wr_bit_q;

	logic signed [COORD_W-1:0] sx_q;
	logic signed [COORD_W-1:0] sy_q;
	logic [COORD_W-1:0] adx_q;
	logic [COORD_W-1:0] ady_q;
	logic               negx_q;
	logic               negy_q;
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;
	logic [2*COORD_W-1:0] prod_a_q;
	logic [2*COORD_W-1:0] prod_b_q;
	logic [ROOT_W-1:0] r_q;
	logic [N_W-1:0]    n_q;
	logic [N_W-1:0]    k_q;
	logic [ROOT_W-1:0] qsx_q;
	logic [ROOT_W-1:0] qsy_q;
	logic [ROOT_W-1:0] rsx_q;
	logic [ROOT_W-1:0] rsy_q;
	logic [ROOT_W-1:0] qx_q;
	logic [ROOT_W-1:0] qy_q;
	logic [ROOT_W-1:0] rx_q;
	logic [ROOT_W-1:0] ry_q;

	logic                in_acc;
	logic                out_free_slot;
	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic                oob;
	logic                cell_hit;
	logic [ROOT_W:0]     sumx;
	logic [ROOT_W:0]     sumy;
	logic                gex;
	logic                gey;

	logic                 mem_rd_en;
	logic [XW-1:0]        mem_rd_addr;
	logic [MAX_HEIGHT-1:0] mem_rd_data;
	logic                 mem_wr_en;
	logic [XW-1:0]        mem_wr_addr;
	logic [MAX_HEIGHT-1:0] mem_wr_data;

	logic                sq_start;
	logic                sq_done;
	logic [ROOT_W-1:0]   sq_root;
	logic                dv_start;
	logic [NUM_W-1:0]    dv_num;
	logic                dv_done;
	logic [NUM_W-1:0]    dv_quot;
	logic [ROOT_W-1:0]   dv_rem;

	assign in_ch.ready   = state_q == S_IDLE;
	assign in_acc        = in_ch.valid && in_ch.ready;
	assign cfg.ready     = 1'b1;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.path_free  = out_free_q;
	assign out_ch.done_action = out_act_q;
	assign out_free_slot = !out_valid_q || out_ch.ready;

	assign dx = (COORD_W+1)'(in_ch.end_x) - (COORD_W+1)'(in_ch.start_x);
	assign dy = (COORD_W+1)'(in_ch.end_y) - (COORD_W+1)'(in_ch.start_y);

	assign oob = px_q[POS_W-1] || py_q[POS_W-1]
		|| (32'(px_q[POS_W-1:FRAC_BITS]) >= 32'(width_q))
		|| (32'(py_q[POS_W-1:FRAC_BITS]) >= 32'(height_q));
	assign cell_hit = mem_rd_data[py_q[FRAC_BITS +: YW]];

	assign sumx = {1'b0, rx_q} + {1'b0, rsx_q};
	assign sumy = {1'b0, ry_q} + {1'b0, rsy_q};
	assign gex  = sumx >= {1'b0, r_q};
	assign gey  = sumy >= {1'b0, r_q};

	assign sq_start = state_q == S_SUM;
	assign dv_start = (state_q == S_EVAL && 32'(n_q) <= CAP && n_q != '0)
		|| (state_q == S_DIVX && dv_done);
	assign dv_num   = (state_q == S_EVAL) ? {adx_q, FRAC_BITS'(0)} : {ady_q, FRAC_BITS'(0)};

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = px_q[FRAC_BITS +: XW];
		mem_wr_en   = 1'b0;
		mem_wr_addr = wr_row_q;
		mem_wr_data = mem_rd_data;
		unique case (state_q)
			S_IDLE: begin
				mem_rd_addr = XW'(in_ch.cell_x);
				mem_rd_en   = in_acc && in_ch.action == ACT_WRITE;
			end
			S_PROBE: mem_rd_en = !oob;
			S_WRITE: begin
				mem_wr_en = 1'b1;
				mem_wr_data[wr_col_q] = wr_bit_q;
			end
			S_CLEAR: begin
				mem_wr_en   = !done_q;
				mem_wr_addr = clr_idx_q;
				mem_wr_data = '0;
			end
			default: ;
		endcase
	end

	gls_grid_mem #(.ROWS(MAX_WIDTH), .WORD(MAX_HEIGHT)) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	gls_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (SQ_IN_W'(prod_a_q) + SQ_IN_W'(prod_b_q)),
		.done     (sq_done),
		.root     (sq_root)
	);

	gls_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (r_q),
		.done   (dv_done),
		.quot   (dv_quot),
		.rem    (dv_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_RST;
			height_q <= H_RST;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_MAP_WIDTH) begin
				width_q <= (32'(cfg.data) > MAX_WIDTH) ? CFG_DW'(MAX_WIDTH) : cfg.data;
			end else if (cfg.index == REG_MAP_HEIGHT) begin
				height_q <= (32'(cfg.data) > MAX_HEIGHT) ? CFG_DW'(MAX_HEIGHT) : cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			boot_q      <= 1'b1;
			done_q      <= 1'b0;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (done_q && out_free_slot) begin
				out_valid_q <= 1'b1;
				done_q      <= 1'b0;
				state_q     <= S_IDLE;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.action)
							ACT_WRITE: begin
								if (32'(in_ch.cell_x) < MAX_WIDTH
									&& 32'(in_ch.cell_y) < MAX_HEIGHT) begin
									state_q <= S_WRITE;
								end else begin
									done_q <= 1'b1;
									state_q <= S_CLEAR;
								end
							end
							ACT_CLEAR: begin
								clr_idx_q <= '0;
								state_q   <= S_CLEAR;
							end
							ACT_TEST: state_q <= S_PROBE;
							default: begin
								done_q  <= 1'b1;
								state_q <= S_CLEAR;
							end
						endcase
					end
				end
				S_WRITE: begin
					done_q  <= 1'b1;
					state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					if (!done_q) begin
						clr_idx_q <= clr_idx_q + 1'b1;
						if (32'(clr_idx_q) == MAX_WIDTH - 1) begin
							clr_idx_q <= '0;
							if (boot_q) begin
								boot_q  <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								done_q <= 1'b1;
							end
						end
					end
				end
				S_PROBE: begin
					if (oob) begin
						done_q  <= 1'b1;
						state_q <= S_CLEAR;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cell_hit) begin
						done_q  <= 1'b1;
						state_q <= S_CLEAR;
					end else if (end_q) begin
						state_q <= S_SQ1;
					end else if (k_q == n_q - 1'b1) begin
						done_q  <= 1'b1;
						state_q <= S_CLEAR;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SUM;
				S_SUM: state_q <= S_SQRT;
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (32'(n_q) > CAP || n_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_CLEAR;
					end else begin
						state_q <= S_DIVX;
					end
				end
				S_DIVX: begin
					if (dv_done) begin
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (dv_done) begin
						state_q <= S_PROBE;
					end
				end
				S_STEP: state_q <= S_POS;
				S_POS: state_q <= S_PROBE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done_q && out_free_slot) begin
			out_free_q <= free_q;
			out_act_q  <= act_q;
		end
		unique case (state_q)
			S_IDLE: begin
				act_q    <= in_ch.action;
				free_q   <= 1'b0;
				end_q    <= 1'b1;
				wr_row_q <= XW'(in_ch.cell_x);
				wr_col_q <= YW'(in_ch.cell_y);
				wr_bit_q <= in_ch.cell_value != '0;
				sx_q     <= in_ch.start_x;
				sy_q     <= in_ch.start_y;
				px_q     <= POS_W'(in_ch.end_x);
				py_q     <= POS_W'(in_ch.end_y);
				negx_q   <= dx[COORD_W];
				negy_q   <= dy[COORD_W];
				adx_q    <= dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
				ady_q    <= dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
			end
			S_CHECK: begin
				end_q <= 1'b0;
				if (!cell_hit && !end_q && k_q == n_q - 1'b1) begin
					free_q <= 1'b1;
				end
				k_q <= k_q + 1'b1;
			end
			S_SQ1: prod_a_q <= adx_q * adx_q;
			S_SQ2: prod_b_q <= ady_q * ady_q;
			S_SQRT: begin
				r_q <= sq_root;
				n_q <= N_W'(sq_root >> FRAC_BITS);
			end
			S_EVAL: free_q <= n_q == '0;
			S_DIVX: begin
				qsx_q <= ROOT_W'(dv_quot);
				rsx_q <= dv_rem;
			end
			S_DIVY: begin
				qsy_q <= ROOT_W'(dv_quot);
				rsy_q <= dv_rem;
				qx_q  <= '0;
				qy_q  <= '0;
				rx_q  <= '0;
				ry_q  <= '0;
				k_q   <= '0;
				px_q  <= POS_W'(sx_q);
				py_q  <= POS_W'(sy_q);
			end
			S_STEP: begin
				qx_q <= qx_q + qsx_q + ROOT_W'(gex);
				qy_q <= qy_q + qsy_q + ROOT_W'(gey);
				rx_q <= gex ? ROOT_W'(sumx - {1'b0, r_q}) : ROOT_W'(sumx);
				ry_q <= gey ? ROOT_W'(sumy - {1'b0, r_q}) : ROOT_W'(sumy);
			end
			S_POS: begin
				px_q <= negx_q ? POS_W'(POS_W'(sx_q) - POS_W'(qx_q))
					: POS_W'(POS_W'(sx_q) + POS_W'(qx_q));
				py_q <= negy_q ? POS_W'(POS_W'(sy_q) - POS_W'(qy_q))
					: POS_W'(POS_W'(sy_q) + POS_W'(qy_q));
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> $past(state_q) == S_PROBE)
		else $error("cell checked without a read");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> k_q < n_q)
		else $error("march ran past its length");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POS |-> rx_q < r_q && ry_q < r_q)
		else $error("step remainder not reduced");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE || done_q)
		else $error("transaction dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		boot_q |-> !in_ch.ready)
		else $error("input taken before grid cleared");
endmodule
`default_nettype wire

>>> verif/gls_tb_if.sv
`timescale 1ns / 1ps
// Interfaces are supplied by the RTL; this file carries a small helper type package.
package gls_tb_pkg;
	import gls_pkg::*;
	typedef struct packed {
		logic [ACT_W-1:0]          action;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [CELL_W-1:0]         cell_x;
		logic [CELL_W-1:0]         cell_y;
		logic [CELL_W-1:0]         cell_value;
	} grid_request_t;
	typedef struct packed {
		logic             path_free;
		logic [ACT_W-1:0] done_action;
	} grid_answer_t;
endpackage

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import gls_pkg::*;
	import gls_tb_pkg::*;

	localparam int GRID_DIM = 256;
	localparam int FRAC = 8;
	localparam int STALL_LIMIT = 20000;
	localparam int REQ_W = $bits(grid_request_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	gls_in_if  in_ch();
	gls_out_if out_ch();
	gls_cfg_if cfg();

	grid_line_of_sight_checker dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink),
		.out_ch(out_ch.source), .cfg(cfg.sink));

	logic [7:0] grid_model [0:GRID_DIM*GRID_DIM-1];
	int unsigned cols_in_use, rows_in_use;
	grid_request_t pending_requests [$];
	grid_answer_t  expected_answers [$];
	int errors = 0;
	int answers_seen = 0;
	int tests_seen = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_off = 1'b0;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic bit cell_blocked(input longint x, input longint y);
		longint cx, cy;
		if (x < 0 || y < 0)
			return 1'b1;
		cx = x >>> FRAC;
		cy = y >>> FRAC;
		if (cx >= cols_in_use || cy >= rows_in_use)
			return 1'b1;
		return grid_model[cx*GRID_DIM + cy] != 0;
	endfunction

	function automatic longint int_root(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint step_offset(input longint k, input longint d,
		input longint r);
		longint q;
		q = ((k << FRAC) * (d < 0 ? -d : d)) / r;
		return d < 0 ? -q : q;
	endfunction

	function automatic bit sight_clear(input grid_request_t t);
		longint sx, sy, ex, ey, dx, dy, r, n;
		sx = t.start_x;
		sy = t.start_y;
		ex = t.end_x;
		ey = t.end_y;
		if (cell_blocked(ex, ey))
			return 1'b0;
		dx = ex - sx;
		dy = ey - sy;
		r = int_root(dx*dx + dy*dy);
		n = r >>> FRAC;
		if (n > 2*GRID_DIM)
			return 1'b0;
		for (longint k = 0; k < n; k++)
			if (cell_blocked(sx + step_offset(k, dx, r), sy + step_offset(k, dy, r)))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic grid_answer_t apply_request(input grid_request_t t);
		grid_answer_t a;
		a.done_action = t.action;
		a.path_free = 1'b0;
		case (t.action)
			ACT_WRITE: grid_model[int'(t.cell_x)*GRID_DIM + int'(t.cell_y)] = t.cell_value;
			ACT_CLEAR: foreach (grid_model[i]) grid_model[i] = 8'd0;
			ACT_TEST: a.path_free = sight_clear(t);
			default: ;
		endcase
		return a;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= '0;
			in_ch.start_x <= '0;
			in_ch.start_y <= '0;
			in_ch.end_x <= '0;
			in_ch.end_y <= '0;
			in_ch.cell_x <= '0;
			in_ch.cell_y <= '0;
			in_ch.cell_value <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_answers.push_back(apply_request(pending_requests.pop_front()));
			if (pending_requests.size() != 0 && !send_idle) begin
				in_ch.valid <= 1'b1;
				{in_ch.action, in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y,
					in_ch.cell_x, in_ch.cell_y, in_ch.cell_value} <= pending_requests[0];
			end else if (!(in_ch.valid && !in_ch.ready)) begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		send_idle <= !calm && ($urandom_range(99) < 25) && !(in_ch.valid && !in_ch.ready);
		recv_idle <= hold_off || (!calm && ($urandom_range(99) < 25));
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		grid_answer_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !recv_idle;
			if (out_ch.valid && out_ch.ready) begin
				answers_seen++;
				if (out_ch.done_action == ACT_TEST)
					tests_seen++;
				if (expected_answers.size() == 0) begin
					report("result with none expected");
				end else begin
					want = expected_answers.pop_front();
					if (out_ch.done_action !== want.done_action)
						report($sformatf("done_action %0d, want %0d", out_ch.done_action,
							want.done_action));
					if (out_ch.path_free !== want.path_free)
						report($sformatf("path_free %0b, want %0b", out_ch.path_free,
							want.path_free));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired");
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v[CFG_DW-1:0];
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_MAP_WIDTH)
			cols_in_use = v[8:0] > GRID_DIM ? GRID_DIM : v[8:0];
		else
			rows_in_use = v[8:0] > GRID_DIM ? GRID_DIM : v[8:0];
	endtask

	task automatic drain();
		wait (pending_requests.size() == 0 && expected_answers.size() == 0 && !in_ch.valid);
		repeat (300) @(posedge clk);
	endtask

	function automatic grid_request_t make_write(input int x, input int y, input int v);
		grid_request_t t;
		t = '0;
		t.action = ACT_WRITE;
		t.cell_x = CELL_W'(x);
		t.cell_y = CELL_W'(y);
		t.cell_value = CELL_W'(v);
		return t;
	endfunction

	function automatic grid_request_t make_test(input int sx, input int sy, input int ex,
		input int ey);
		grid_request_t t;
		t = '0;
		t.action = ACT_TEST;
		t.start_x = COORD_W'(sx);
		t.start_y = COORD_W'(sy);
		t.end_x = COORD_W'(ex);
		t.end_y = COORD_W'(ey);
		return t;
	endfunction

	function automatic int near_coord(input int span);
		return $urandom_range(span*256 + 511) - 256;
	endfunction

	function automatic grid_request_t random_request(input int span);
		grid_request_t t;
		int pick;
		t = '0;
		pick = $urandom_range(99);
		if (pick < 40) begin
			t = make_write($urandom_range(span-1), $urandom_range(span-1),
				$urandom_range(3) == 0 ? 0 : $urandom_range(255));
		end else if (pick < 42) begin
			t.action = ACT_CLEAR;
		end else if (pick < 45) begin
			t = REQ_W'($urandom());
			t.action = ACT_UNUSED;
		end else if (pick < 48) begin
			t = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom()});
			t.action = ACT_TEST;
		end else begin
			t = make_test(near_coord(span), near_coord(span), near_coord(span),
				near_coord(span));
			if ($urandom_range(3) == 0) begin
				t.end_x = COORD_W'(t.start_x + $urandom_range(300) - 150);
				t.end_y = COORD_W'(t.start_y + $urandom_range(300) - 150);
			end
		end
		t.cell_value = t.action == ACT_WRITE ? t.cell_value : CELL_W'($urandom());
		return t;
	endfunction

	initial begin
		grid_request_t t;
		int span;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		cols_in_use = GRID_DIM;
		rows_in_use = GRID_DIM;
		foreach (grid_model[i]) grid_model[i] = 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every action, special cases
		pending_requests.push_back(make_test(0, 0, 0, 0));
		pending_requests.push_back(make_test(100, 100, 120, 90));
		pending_requests.push_back(make_write(255, 255, 255));
		pending_requests.push_back(make_write(0, 0, 1));
		pending_requests.push_back(make_test(65535, 65535, 65535, 65535));
		pending_requests.push_back(make_test(128, 128, 5000, 7000));
		pending_requests.push_back(make_test(5000, 7000, 300, 300));
		pending_requests.push_back(make_test(-131072, -131072, 131071, 131071));
		pending_requests.push_back(make_test(131071, 131071, 100, 100));
		pending_requests.push_back(make_test(-131072, 300, 600, 300));
		pending_requests.push_back(make_write(40, 20, 8'hAA));
		pending_requests.push_back(make_test(512, 5200, 20000, 5200));
		pending_requests.push_back(make_test(10300, 5200, 10300, 5200));
		t = '1;
		pending_requests.push_back(t);
		t = '0;
		t.action = ACT_CLEAR;
		pending_requests.push_back(t);
		pending_requests.push_back(make_test(65535, 65535, 0, 0));
		drain();

		write_register(REG_MAP_WIDTH, 0);
		write_register(REG_MAP_HEIGHT, 511);
		pending_requests.push_back(make_test(10, 10, 20, 20));
		drain();
		write_register(REG_MAP_WIDTH, 511);
		write_register(REG_MAP_HEIGHT, 0);
		pending_requests.push_back(make_test(10, 10, 20, 20));
		drain();
		write_register(REG_MAP_WIDTH, 1);
		write_register(REG_MAP_HEIGHT, 1);
		pending_requests.push_back(make_test(10, 10, 250, 200));
		pending_requests.push_back(make_test(10, 10, 256, 20));
		pending_requests.push_back(make_write(200, 3, 9));
		pending_requests.push_back(make_test(255, 255, 0, 0));
		drain();

		// random phases across several map sizes
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin span = 256; write_register(REG_MAP_WIDTH, 256);
					write_register(REG_MAP_HEIGHT, 256); end
				1: begin span = 16; write_register(REG_MAP_WIDTH, 16);
					write_register(REG_MAP_HEIGHT, 12); end
				2: begin span = 8; write_register(REG_MAP_WIDTH, 2);
					write_register(REG_MAP_HEIGHT, 256); end
				3: begin span = 24; write_register(REG_MAP_WIDTH, 20);
					write_register(REG_MAP_HEIGHT, 300); end
				default: begin span = 12; write_register(REG_MAP_WIDTH, 9);
					write_register(REG_MAP_HEIGHT, 9); end
			endcase
			calm = (phase == 1);
			for (int i = 0; i < 185; i++)
				pending_requests.push_back(random_request(phase == 0 ? 32 : span));
			if (phase == 2) begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			drain();
		end
		calm = 1'b0;

		$display("ran %0d results, %0d of them path tests, over several map sizes",
			answers_seen, tests_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> sim.f
rtl/gls_pkg.sv
rtl/gls_in_if.sv
rtl/gls_out_if.sv
rtl/gls_cfg_if.sv
rtl/gls_grid_mem.sv
rtl/gls_sqrt.sv
rtl/gls_div.sv
rtl/grid_line_of_sight_checker.sv
verif/gls_tb_if.sv
verif/testbench.sv
